// ===== rtl/rlpa_pkg.sv =====
package rlpa_pkg;

    localparam int unsigned CHAN_W      = 8;
    localparam int unsigned LUMA_W      = 6;
    localparam int unsigned PHASE_W     = 8;
    localparam int unsigned AMP_W       = 4;
    localparam int unsigned HUE_W       = 9;
    localparam int unsigned CFG_IDX_W   = 2;
    localparam int unsigned CFG_DATA_W  = 9;

    localparam int unsigned HNUM_W      = 14;
    localparam int unsigned HQ_W        = 6;
    localparam int unsigned ANUM_W      = 12;

    localparam logic [CFG_IDX_W-1:0] CFG_HUE_OFFSET = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_LUMA_FLOOR = 2'd1;

    localparam logic [HUE_W-1:0]  HUE_OFFSET_RST = 9'd112;
    localparam logic [LUMA_W-1:0] LUMA_FLOOR_RST = 6'd12;

    localparam logic [9:0] HUE_FULL     = 10'd360;
    localparam logic [9:0] HUE_FULL_X2  = 10'd720;
    localparam logic [9:0] BASE_RED     = 10'd360;
    localparam logic [9:0] BASE_GREEN   = 10'd120;
    localparam logic [9:0] BASE_BLUE    = 10'd240;

    localparam int unsigned PROD_W      = 27;
    localparam logic [17:0] PHASE_RECIP = 18'd186933;
    localparam int unsigned PHASE_SHIFT = 18;

    typedef enum logic [1:0] {
        SEC_RED,
        SEC_GREEN,
        SEC_BLUE
    } t_sector;

    typedef struct packed {
        logic [CHAN_W-1:0] red;
        logic [CHAN_W-1:0] green;
        logic [CHAN_W-1:0] blue;
    } t_pix_in;

    typedef struct packed {
        logic [LUMA_W-1:0]  luma;
        logic [PHASE_W-1:0] phase;
        logic [AMP_W-1:0]   amplitude;
    } t_pix_out;

    typedef struct packed {
        logic [HNUM_W-1:0] hue_rem;
        logic [HQ_W-1:0]   hue_q;
        logic [CHAN_W-1:0] hue_d;
        logic              neg;
        t_sector           sector;
        logic [ANUM_W-1:0] amp_rem;
        logic [AMP_W-1:0]  amp_q;
        logic [CHAN_W-1:0] amp_d;
        logic [CHAN_W-1:0] hi;
    } t_div;

    typedef struct packed {
        logic              qbit;
        logic [HNUM_W-1:0] rem;
    } t_step;

    function automatic t_step div_step(logic [HNUM_W-1:0] rem, logic [CHAN_W-1:0] d,
                                       logic [2:0] k);
        logic [HNUM_W-1:0] dk;
        t_step res;
        dk = HNUM_W'(d) << k;
        if (rem >= dk) begin
            res.qbit = 1'b1;
            res.rem  = rem - dk;
        end else begin
            res.qbit = 1'b0;
            res.rem  = rem;
        end
        return res;
    endfunction

endpackage

// ===== rtl/rlpa_front.sv =====
module rlpa_front (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_en,
    input  logic              i_valid,
    input  rlpa_pkg::t_pix_in i_pix,
    output logic              o_valid,
    output rlpa_pkg::t_div    o_item
);

    logic [rlpa_pkg::CHAN_W-1:0] hi;
    logic [rlpa_pkg::CHAN_W-1:0] lo;
    logic [rlpa_pkg::CHAN_W-1:0] diff;
    logic [rlpa_pkg::CHAN_W-1:0] da;
    logic [rlpa_pkg::CHAN_W-1:0] db;
    logic [rlpa_pkg::CHAN_W:0]   dsgn;
    logic [rlpa_pkg::CHAN_W-1:0] mag;
    rlpa_pkg::t_sector           sector;
    rlpa_pkg::t_div              n_item;
    rlpa_pkg::t_div              r_item;
    logic                        r_valid;

    always_comb begin
        hi = i_pix.red;
        lo = i_pix.red;
        if (i_pix.green > hi) hi = i_pix.green;
        if (i_pix.blue > hi) hi = i_pix.blue;
        if (i_pix.green < lo) lo = i_pix.green;
        if (i_pix.blue < lo) lo = i_pix.blue;
        diff = hi - lo;

        if (hi == i_pix.red) begin
            sector = rlpa_pkg::SEC_RED;
            da = i_pix.green;
            db = i_pix.blue;
        end else if (hi == i_pix.green) begin
            sector = rlpa_pkg::SEC_GREEN;
            da = i_pix.blue;
            db = i_pix.red;
        end else begin
            sector = rlpa_pkg::SEC_BLUE;
            da = i_pix.red;
            db = i_pix.green;
        end
        dsgn = {1'b0, da} - {1'b0, db};
        mag  = dsgn[rlpa_pkg::CHAN_W] ? rlpa_pkg::CHAN_W'(-dsgn)
                                      : dsgn[rlpa_pkg::CHAN_W-1:0];

        n_item.hue_rem = (rlpa_pkg::HNUM_W'(mag) << 6) - (rlpa_pkg::HNUM_W'(mag) << 2);
        n_item.hue_q   = '0;
        n_item.hue_d   = (diff == '0) ? rlpa_pkg::CHAN_W'(1) : diff;
        n_item.neg     = dsgn[rlpa_pkg::CHAN_W];
        n_item.sector  = sector;
        n_item.amp_rem = (rlpa_pkg::ANUM_W'(diff) << 4) - rlpa_pkg::ANUM_W'(diff);
        n_item.amp_q   = '0;
        n_item.amp_d   = (hi == '0) ? rlpa_pkg::CHAN_W'(1) : hi;
        n_item.hi      = hi;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_en) begin
            r_valid <= i_valid;
        end
        if (i_en) begin
            r_item <= n_item;
        end
    end

    assign o_valid = r_valid;
    assign o_item  = r_item;

endmodule

// ===== rtl/rlpa_div.sv =====
module rlpa_div (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_en,
    input  logic           i_valid,
    input  rlpa_pkg::t_div i_item,
    output logic           o_valid,
    output rlpa_pkg::t_div o_item
);

    rlpa_pkg::t_div r_stg [3];
    rlpa_pkg::t_div n_stg [3];
    logic [2:0]     r_valid;

    function automatic rlpa_pkg::t_div hue_bits(rlpa_pkg::t_div it, logic [2:0] k);
        rlpa_pkg::t_step s1;
        rlpa_pkg::t_step s0;
        rlpa_pkg::t_div  res;
        res = it;
        s1 = rlpa_pkg::div_step(it.hue_rem, it.hue_d, k + 3'd1);
        s0 = rlpa_pkg::div_step(s1.rem, it.hue_d, k);
        res.hue_rem = s0.rem;
        res.hue_q   = it.hue_q | (rlpa_pkg::HQ_W'({s1.qbit, s0.qbit}) << k);
        return res;
    endfunction

    function automatic rlpa_pkg::t_div amp_bits(rlpa_pkg::t_div it, logic [2:0] k);
        rlpa_pkg::t_step s1;
        rlpa_pkg::t_step s0;
        rlpa_pkg::t_div  res;
        res = it;
        s1 = rlpa_pkg::div_step(rlpa_pkg::HNUM_W'(it.amp_rem), it.amp_d, k + 3'd1);
        s0 = rlpa_pkg::div_step(s1.rem, it.amp_d, k);
        res.amp_rem = rlpa_pkg::ANUM_W'(s0.rem);
        res.amp_q   = it.amp_q | (rlpa_pkg::AMP_W'({s1.qbit, s0.qbit}) << k);
        return res;
    endfunction

    always_comb begin
        n_stg[0] = amp_bits(hue_bits(i_item, 3'd4), 3'd2);
        n_stg[1] = amp_bits(hue_bits(r_stg[0], 3'd2), 3'd0);
        n_stg[2] = hue_bits(r_stg[1], 3'd0);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= '0;
        end else if (i_en) begin
            r_valid <= {r_valid[1:0], i_valid};
        end
        if (i_en) begin
            r_stg[0] <= n_stg[0];
            r_stg[1] <= n_stg[1];
            r_stg[2] <= n_stg[2];
        end
    end

    assign o_valid = r_valid[2];
    assign o_item  = r_stg[2];

endmodule

// ===== rtl/rlpa_back.sv =====
module rlpa_back (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_en,
    input  logic                            i_valid,
    input  rlpa_pkg::t_div                  i_item,
    input  logic [rlpa_pkg::HUE_W-1:0]      i_hue_offset,
    input  logic [rlpa_pkg::LUMA_W-1:0]     i_luma_floor,
    output logic                            o_valid,
    output rlpa_pkg::t_pix_out              o_pix
);

    logic [6:0]                      adj;
    logic [9:0]                      base;
    logic [9:0]                      raw;
    logic [rlpa_pkg::HUE_W-1:0]      n_hue0;
    logic [13:0]                     lx;
    logic [5:0]                      lq0;
    logic [8:0]                      lr;
    logic [rlpa_pkg::LUMA_W-1:0]     n_luma;
    logic [9:0]                      hsum;
    logic [rlpa_pkg::HUE_W-1:0]      n_hue;
    logic [rlpa_pkg::HUE_W-1:0]      praw;
    rlpa_pkg::t_pix_out              n_pix;

    logic [rlpa_pkg::HUE_W-1:0]      r_hue0;
    logic [rlpa_pkg::HUE_W-1:0]      r_hue;
    logic [rlpa_pkg::PROD_W-1:0]     r_prod;
    logic [rlpa_pkg::LUMA_W-1:0]     r_luma [3];
    logic [rlpa_pkg::AMP_W-1:0]      r_amp [3];
    logic [3:0]                      r_valid;
    rlpa_pkg::t_pix_out              r_pix;

    always_comb begin
        adj = 7'(i_item.hue_q) + 7'(i_item.neg && (i_item.hue_rem != '0));
        case (i_item.sector)
            rlpa_pkg::SEC_RED:   base = rlpa_pkg::BASE_RED;
            rlpa_pkg::SEC_GREEN: base = rlpa_pkg::BASE_GREEN;
            rlpa_pkg::SEC_BLUE:  base = rlpa_pkg::BASE_BLUE;
            default:             base = rlpa_pkg::BASE_RED;
        endcase
        raw    = i_item.neg ? base - 10'(adj) : base + 10'(adj);
        n_hue0 = (raw >= rlpa_pkg::HUE_FULL) ? rlpa_pkg::HUE_W'(raw - rlpa_pkg::HUE_FULL)
                                             : rlpa_pkg::HUE_W'(raw);

        lx     = (14'(i_item.hi) << 6) - 14'(i_item.hi);
        lq0    = lx[13:8];
        lr     = 9'(lx[7:0]) + 9'(lq0);
        n_luma = lq0 + 6'(lr >= 9'd255);

        hsum = 10'(r_hue0) + 10'(i_hue_offset);
        if (hsum >= rlpa_pkg::HUE_FULL_X2) begin
            n_hue = rlpa_pkg::HUE_W'(hsum - rlpa_pkg::HUE_FULL_X2);
        end else if (hsum >= rlpa_pkg::HUE_FULL) begin
            n_hue = rlpa_pkg::HUE_W'(hsum - rlpa_pkg::HUE_FULL);
        end else begin
            n_hue = rlpa_pkg::HUE_W'(hsum);
        end

        praw = r_prod[rlpa_pkg::PHASE_SHIFT +: rlpa_pkg::HUE_W];
        if (r_amp[2] == '0) begin
            n_pix.phase = '0;
        end else if (praw[rlpa_pkg::HUE_W-1]) begin
            n_pix.phase = '1;
        end else begin
            n_pix.phase = praw[rlpa_pkg::PHASE_W-1:0];
        end
        n_pix.amplitude = r_amp[2];
        n_pix.luma      = (r_luma[2] < i_luma_floor) ? i_luma_floor : r_luma[2];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= '0;
        end else if (i_en) begin
            r_valid <= {r_valid[2:0], i_valid};
        end
        if (i_en) begin
            r_hue0    <= n_hue0;
            r_luma[0] <= n_luma;
            r_amp[0]  <= i_item.amp_q;
            r_hue     <= n_hue;
            r_luma[1] <= r_luma[0];
            r_amp[1]  <= r_amp[0];
            r_prod    <= rlpa_pkg::PROD_W'(r_hue) * rlpa_pkg::PROD_W'(rlpa_pkg::PHASE_RECIP);
            r_luma[2] <= r_luma[1];
            r_amp[2]  <= r_amp[1];
            r_pix     <= n_pix;
        end
    end

    assign o_valid = r_valid[3];
    assign o_pix   = r_pix;

endmodule

// ===== rtl/rgb_to_luma_phase_amplitude_top.sv =====
// RGB pixel to video luma, chroma phase and chroma amplitude.
//
// Input channel: i_valid / o_stall carrying i_pix (red, green, blue). A
// transaction completes at a clock edge with i_valid high and o_stall low.
// Output channel: o_valid / i_stall carrying o_pix (luma, phase, amplitude),
// one result per input transaction, in order.
// Configuration: i_cfg_valid / o_cfg_ready with i_cfg_index and i_cfg_data;
// index 0 is the hue offset, index 1 the luma floor, others are dropped.
// o_cfg_ready is always high; write only while the pipeline is empty.
//
// o_valid rises once the transaction has passed the front register, the
// divider stages and the back-end registers; throughput is one pixel per
// cycle while the output is unstalled. The hue divider runs two quotient bits
// per stage over three stages; the phase scaling is one registered multiply.
// When the output holds a result and i_stall is high, the whole pipeline
// holds and o_stall rises in the same cycle; nothing is lost or repeated.
// Reset (i_rst_n low, synchronous) empties the pipeline and loads the hue
// offset with 112 and the luma floor with 12.
module rgb_to_luma_phase_amplitude_top (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_valid,
    output logic                                o_stall,
    input  rlpa_pkg::t_pix_in                   i_pix,
    output logic                                o_valid,
    input  logic                                i_stall,
    output rlpa_pkg::t_pix_out                  o_pix,
    input  logic                                i_cfg_valid,
    output logic                                o_cfg_ready,
    input  logic [rlpa_pkg::CFG_IDX_W-1:0]      i_cfg_index,
    input  logic [rlpa_pkg::CFG_DATA_W-1:0]     i_cfg_data
);

    logic [rlpa_pkg::HUE_W-1:0]  r_hue_offset;
    logic [rlpa_pkg::LUMA_W-1:0] r_luma_floor;
    logic                        en;
    logic                        front_valid;
    rlpa_pkg::t_div              front_item;
    logic                        div_valid;
    rlpa_pkg::t_div              div_item;

    assign en          = !o_valid || !i_stall;
    assign o_stall     = !en;
    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_hue_offset <= rlpa_pkg::HUE_OFFSET_RST;
            r_luma_floor <= rlpa_pkg::LUMA_FLOOR_RST;
        end else if (i_cfg_valid && o_cfg_ready) begin
            case (i_cfg_index)
                rlpa_pkg::CFG_HUE_OFFSET: r_hue_offset <= i_cfg_data;
                rlpa_pkg::CFG_LUMA_FLOOR: r_luma_floor <= i_cfg_data[rlpa_pkg::LUMA_W-1:0];
                default: ;
            endcase
        end
    end

    rlpa_front u_front (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (en),
        .i_valid (i_valid),
        .i_pix   (i_pix),
        .o_valid (front_valid),
        .o_item  (front_item)
    );

    rlpa_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (en),
        .i_valid (front_valid),
        .i_item  (front_item),
        .o_valid (div_valid),
        .o_item  (div_item)
    );

    rlpa_back u_back (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_en         (en),
        .i_valid      (div_valid),
        .i_item       (div_item),
        .i_hue_offset (r_hue_offset),
        .i_luma_floor (r_luma_floor),
        .o_valid      (o_valid),
        .o_pix        (o_pix)
    );

endmodule

// ===== sim/rgb_to_luma_phase_amplitude_top_tb.sv =====
`timescale 1ns / 1ps

module rgb_to_luma_phase_amplitude_top_tb;

    localparam int unsigned CLK_PERIOD      = 20;
    localparam int unsigned RESET_CYCLES    = 11;
    localparam int unsigned PIPE_LATENCY    = 8;
    localparam int unsigned CYCLE_LIMIT     = 800000;
    localparam int unsigned ITEMS_PER_PHASE = 270;
    localparam int unsigned NUM_PHASES      = 7;

    localparam logic [rlpa_pkg::CFG_IDX_W-1:0] CFG_UNUSED_LO = 2'd2;
    localparam logic [rlpa_pkg::CFG_IDX_W-1:0] CFG_UNUSED_HI = 2'd3;

    class t_rlpa_scoreboard;
        rlpa_pkg::t_pix_out          expected_pix[$];
        logic [rlpa_pkg::HUE_W-1:0]  hue_offset;
        logic [rlpa_pkg::LUMA_W-1:0] luma_floor;
        int unsigned                 errors;

        function new();
            hue_offset = rlpa_pkg::HUE_OFFSET_RST;
            luma_floor = rlpa_pkg::LUMA_FLOOR_RST;
            errors     = 0;
        endfunction

        function void write_reg(logic [rlpa_pkg::CFG_IDX_W-1:0] idx,
                                logic [rlpa_pkg::CFG_DATA_W-1:0] data);
            if (idx == rlpa_pkg::CFG_HUE_OFFSET) begin
                hue_offset = data[rlpa_pkg::HUE_W-1:0];
            end else if (idx == rlpa_pkg::CFG_LUMA_FLOOR) begin
                luma_floor = data[rlpa_pkg::LUMA_W-1:0];
            end
        endfunction

        function rlpa_pkg::t_pix_out convert_pixel(rlpa_pkg::t_pix_in p);
            int                 r, g, b, hi, lo, diff, base, delta, hue, ph, amp, lm;
            rlpa_pkg::t_pix_out res;
            r  = int'(p.red);
            g  = int'(p.green);
            b  = int'(p.blue);
            hi = r;
            lo = r;
            if (g > hi) hi = g;
            if (b > hi) hi = b;
            if (g < lo) lo = g;
            if (b < lo) lo = b;
            diff = hi - lo;
            if (diff == 0) begin
                hue = 0;
            end else begin
                // red wins ties over green, green over blue
                if (hi == r) begin
                    base  = int'(rlpa_pkg::BASE_RED);
                    delta = g - b;
                end else if (hi == g) begin
                    base  = int'(rlpa_pkg::BASE_GREEN);
                    delta = b - r;
                end else begin
                    base  = int'(rlpa_pkg::BASE_BLUE);
                    delta = r - g;
                end
                hue = ((60 * delta + base * diff) / diff) % int'(rlpa_pkg::HUE_FULL);
            end
            hue = (hue + int'(hue_offset)) % int'(rlpa_pkg::HUE_FULL);
            ph  = (hue * 256) / 359;
            if (ph > 255) ph = 255;
            amp = (hi == 0) ? 0 : (15 * diff) / hi;
            if (amp == 0) ph = 0;
            lm = (63 * hi) / 255;
            if (lm < int'(luma_floor)) lm = int'(luma_floor);
            res.luma      = rlpa_pkg::LUMA_W'(lm);
            res.phase     = rlpa_pkg::PHASE_W'(ph);
            res.amplitude = rlpa_pkg::AMP_W'(amp);
            return res;
        endfunction

        function void note_pixel(rlpa_pkg::t_pix_in p);
            expected_pix.push_back(convert_pixel(p));
        endfunction

        function void check_pixel(rlpa_pkg::t_pix_out got);
            rlpa_pkg::t_pix_out want;
            if (expected_pix.size() == 0) begin
                $error("unexpected result: luma %0d phase %0d amplitude %0d",
                       got.luma, got.phase, got.amplitude);
                errors++;
                return;
            end
            want = expected_pix.pop_front();
            if (got.luma !== want.luma) begin
                $error("luma mismatch: expected %0d, actual %0d", want.luma, got.luma);
                errors++;
            end
            if (got.phase !== want.phase) begin
                $error("phase mismatch: expected %0d, actual %0d", want.phase, got.phase);
                errors++;
            end
            if (got.amplitude !== want.amplitude) begin
                $error("amplitude mismatch: expected %0d, actual %0d",
                       want.amplitude, got.amplitude);
                errors++;
            end
        endfunction

        function int pending();
            return expected_pix.size();
        endfunction
    endclass

    logic                            i_clk       = 1'b0;
    logic                            i_rst_n     = 1'b0;
    logic                            i_valid     = 1'b0;
    logic                            o_stall;
    rlpa_pkg::t_pix_in               i_pix       = '0;
    logic                            o_valid;
    logic                            i_stall     = 1'b0;
    rlpa_pkg::t_pix_out              o_pix;
    logic                            i_cfg_valid = 1'b0;
    logic                            o_cfg_ready;
    logic [rlpa_pkg::CFG_IDX_W-1:0]  i_cfg_index = '0;
    logic [rlpa_pkg::CFG_DATA_W-1:0] i_cfg_data  = '0;

    t_rlpa_scoreboard luma_sb;
    int unsigned      cycle_count = 0;

    rgb_to_luma_phase_amplitude_top DUT (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_valid     (i_valid),
        .o_stall     (o_stall),
        .i_pix       (i_pix),
        .o_valid     (o_valid),
        .i_stall     (i_stall),
        .o_pix       (o_pix),
        .i_cfg_valid (i_cfg_valid),
        .o_cfg_ready (o_cfg_ready),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data)
    );

    initial begin
        forever begin
            #(CLK_PERIOD / 2) i_clk = ~i_clk;
        end
    end

    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("rgb_to_luma_phase_amplitude_top_tb: FAIL");
            $finish;
        end
    end

    always @(posedge i_clk) begin
        if (i_rst_n && o_valid === 1'b1 && i_stall == 1'b0) begin
            luma_sb.check_pixel(o_pix);
        end
    end

    function automatic int gap_len(bit dense);
        int roll;
        roll = $urandom_range(99);
        if (dense || roll < 55) return 0;
        if (roll < 85) return $urandom_range(1, 3);
        if (roll < 96) return $urandom_range(4, 10);
        return $urandom_range(15, 30);
    endfunction

    initial begin
        while (!i_rst_n) @(posedge i_clk);
        forever begin
            if ($urandom_range(9) == 0) begin
                i_stall <= 1'b0;
                repeat ($urandom_range(40, 160)) @(posedge i_clk);
            end else begin
                i_stall <= 1'b1;
                repeat (($urandom_range(9) == 0) ? $urandom_range(10, 30)
                                                 : $urandom_range(1, 3)) @(posedge i_clk);
                i_stall <= 1'b0;
                repeat ($urandom_range(1, 6)) @(posedge i_clk);
            end
        end
    end

    function automatic rlpa_pkg::t_pix_in random_pixel();
        rlpa_pkg::t_pix_in p;
        int                kind;
        logic [7:0]        v;
        logic [7:0]        w;
        kind = $urandom_range(99);
        v    = 8'($urandom_range(255));
        w    = 8'($urandom_range(v));
        if (kind < 55) begin
            p.red   = 8'($urandom_range(255));
            p.green = 8'($urandom_range(255));
            p.blue  = 8'($urandom_range(255));
        end else if (kind < 66) begin
            p = '{v, v, v};
        end else if (kind < 78) begin
            case ($urandom_range(2))
                0: p = '{v, v, w};
                1: p = '{w, v, v};
                default: p = '{v, w, v};
            endcase
        end else if (kind < 88) begin
            p.red   = ($urandom_range(1) != 0) ? 8'hFF : 8'h00;
            p.green = ($urandom_range(2) == 0) ? 8'hFF : 8'($urandom_range(255));
            p.blue  = ($urandom_range(2) == 0) ? 8'h00 : 8'($urandom_range(255));
        end else if (kind < 94) begin
            v       = 8'($urandom_range(3, 255));
            p.red   = v - 8'($urandom_range(3));
            p.green = v - 8'($urandom_range(3));
            p.blue  = v - 8'($urandom_range(3));
        end else begin
            p.red   = 8'($urandom_range(24));
            p.green = 8'($urandom_range(24));
            p.blue  = 8'($urandom_range(24));
        end
        return p;
    endfunction

    task automatic send_pixel(input rlpa_pkg::t_pix_in p, input int gap);
        if (gap > 0) begin
            i_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_valid <= 1'b1;
        i_pix   <= p;
        do @(posedge i_clk); while (o_stall !== 1'b0);
        luma_sb.note_pixel(p);
    endtask

    task automatic wait_idle();
        i_valid <= 1'b0;
        do @(posedge i_clk); while (luma_sb.pending() != 0);
    endtask

    task automatic write_reg(input logic [rlpa_pkg::CFG_IDX_W-1:0] idx,
                             input logic [rlpa_pkg::CFG_DATA_W-1:0] data);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= data;
        do @(posedge i_clk); while (o_cfg_ready !== 1'b1);
        luma_sb.write_reg(idx, data);
    endtask

    task automatic end_cfg();
        i_cfg_valid <= 1'b0;
    endtask

    initial begin
        rlpa_pkg::t_pix_in               directed[$];
        logic [rlpa_pkg::CFG_DATA_W-1:0] offset_set [NUM_PHASES];
        logic [rlpa_pkg::CFG_DATA_W-1:0] floor_set  [NUM_PHASES];
        bit                              dense;

        luma_sb    = new();
        offset_set = '{9'd0, 9'd359, 9'd511, 9'd360, 9'd1, 9'd112, 9'd0};
        floor_set  = '{9'd0, 9'd63, 9'h1FF, 9'h040, 9'd30, 9'd12, 9'd0};
        offset_set[NUM_PHASES-1] = 9'($urandom_range(511));
        floor_set[NUM_PHASES-1]  = 9'($urandom_range(511));

        repeat (RESET_CYCLES) @(posedge i_clk);
        i_rst_n <= 1'b1;

        directed = '{
            '{8'h00, 8'h00, 8'h00}, '{8'hFF, 8'hFF, 8'hFF}, '{8'h80, 8'h80, 8'h80},
            '{8'hFF, 8'h00, 8'h00}, '{8'h00, 8'hFF, 8'h00}, '{8'h00, 8'h00, 8'hFF},
            '{8'hFF, 8'hFF, 8'h00}, '{8'h00, 8'hFF, 8'hFF}, '{8'hFF, 8'h00, 8'hFF},
            '{8'hFF, 8'hFE, 8'hFE}, '{8'hFF, 8'h00, 8'h01}, '{8'h01, 8'h00, 8'h00},
            '{8'h0A, 8'h05, 8'h02}, '{8'h55, 8'hAA, 8'h33}, '{8'h12, 8'h34, 8'h56},
            '{8'hC0, 8'h40, 8'hE0}
        };
        foreach (directed[i]) send_pixel(directed[i], $urandom_range(1));
        wait_idle();

        // zero offset: pure-red hue near 359 hits the phase saturation
        write_reg(rlpa_pkg::CFG_HUE_OFFSET, 9'd0);
        write_reg(rlpa_pkg::CFG_LUMA_FLOOR, 9'd0);
        end_cfg();
        send_pixel('{8'hFF, 8'h00, 8'h01}, 0);
        send_pixel('{8'h00, 8'h00, 8'h00}, 0);
        send_pixel('{8'h03, 8'h00, 8'h02}, 0);
        wait_idle();

        for (int ph = 0; ph < NUM_PHASES; ph++) begin
            write_reg(CFG_UNUSED_LO, 9'($urandom_range(511)));
            write_reg(rlpa_pkg::CFG_HUE_OFFSET, offset_set[ph]);
            write_reg(rlpa_pkg::CFG_LUMA_FLOOR, floor_set[ph]);
            write_reg(CFG_UNUSED_HI, 9'($urandom_range(511)));
            end_cfg();
            for (int n = 0; n < ITEMS_PER_PHASE; n++) begin
                if (n % 45 == 0) dense = ($urandom_range(3) == 0);
                send_pixel(random_pixel(), gap_len(dense));
            end
            wait_idle();
        end

        repeat (PIPE_LATENCY * 4) @(posedge i_clk);
        if (luma_sb.errors == 0 && luma_sb.pending() == 0) begin
            $display("rgb_to_luma_phase_amplitude_top_tb: PASS");
        end else begin
            $display("rgb_to_luma_phase_amplitude_top_tb: FAIL");
        end
        $finish;
    end

endmodule
